[src/charset_keyspace_enumerator_utf8_unit_assert.svh]
// ----------------------------------------------------------------------------
// keyspace enumerator assertion macros
// shared property forms for the enumerator checks
// ----------------------------------------------------------------------------
`ifndef CHARSET_KEYSPACE_ENUMERATOR_UTF8_UNIT_ASSERT_SVH
`define CHARSET_KEYSPACE_ENUMERATOR_UTF8_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CKE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cke_pkg.sv]
// ----------------------------------------------------------------------------
// keyspace enumerator package
// shared types, constants and utf-8 encode helpers
// ----------------------------------------------------------------------------
package cke_pkg;

    localparam int CHARSET_DEPTH_DEF = 256;
    localparam int MAX_POSITIONS_DEF = 16;
    localparam int MAX_RESULTS       = 64;
    localparam int BCW               = $clog2(MAX_RESULTS);

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int CHARSET_SIZE_RST = 1;
    localparam int MAX_LENGTH_RST   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHARSET_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_NEXT    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK,
        ST_EMIT,
        ST_WALK,
        ST_EXH
    } state_t;

    // broadcast command to the digit chain
    typedef struct packed {
        logic clear;
        logic rotate;
        logic inject;
    } chain_cmd_t;

    // status back from the digit chain
    typedef struct packed {
        logic any_tok;
        logic wrap;
    } chain_stat_t;

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp[CP_W-1:7] == '0) begin
            n = 3'd1;
        end else if (cp[CP_W-1:11] == '0) begin
            n = 3'd2;
        end else if (cp[CP_W-1:16] == '0) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
                                                    input logic [1:0] k);
        logic [BYTE_W-1:0] b;
        case (utf8_len(cp))
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[src/cke_ram.sv]
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered data
// ----------------------------------------------------------------------------
module cke_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/cke_cell.sv]
// ----------------------------------------------------------------------------
// digit cell
// one odometer position: digit, carry token, rotate link to its neighbor
// ----------------------------------------------------------------------------
module cke_cell #(
    parameter int DW  = 8,
    parameter int PW  = 4,
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cke_pkg::chain_cmd_t    cmd,
    input  logic [DW-1:0]          radix_m1,
    input  logic [PW-1:0]          leftmost,
    input  logic [PW-1:0]          len_m1,
    input  logic [DW-1:0]          digit_in,
    input  logic                   carry_in,
    output logic [DW-1:0]          digit,
    output logic                   carry_out,
    output logic                   tok
);

    logic [DW-1:0] digit_reg;
    logic [DW-1:0] digit_next;
    logic          tok_reg;
    logic          tok_next;
    logic          active;
    logic          wrap;

    // positions left of the leftmost in use just absorb the carry
    assign active = (PW'(IDX) >= leftmost);
    assign wrap   = tok_reg && active && (digit_reg == radix_m1);

    always_comb
    begin
        digit_next = digit_reg;
        if (cmd.clear)
        begin
            digit_next = '0;
        end else if (cmd.rotate)
        begin
            digit_next = digit_in;
        end else if (tok_reg && active)
        begin
            digit_next = wrap ? '0 : DW'(digit_reg + 1'b1);
        end

        if (cmd.clear)
        begin
            tok_next = 1'b0;
        end else if (cmd.inject)
        begin
            tok_next = (PW'(IDX) == len_m1);
        end else
        begin
            tok_next = carry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            tok_reg   <= 1'b0;
        end else
        begin
            digit_reg <= digit_next;
            tok_reg   <= tok_next;
        end
    end

    assign digit     = digit_reg;
    assign carry_out = wrap;
    assign tok       = tok_reg;

endmodule

[src/cke_chain.sv]
// ----------------------------------------------------------------------------
// digit chain
// ring of digit cells; rotates toward cell 0, carries walk toward cell 0
// ----------------------------------------------------------------------------
module cke_chain #(
    parameter int DW   = 8,
    parameter int PW   = 4,
    parameter int MAXP = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cke_pkg::chain_cmd_t   cmd,
    input  logic [DW-1:0]         radix_m1,
    input  logic [PW-1:0]         leftmost,
    input  logic [PW-1:0]         len_m1,
    output logic [DW-1:0]         head,
    output cke_pkg::chain_stat_t  stat
);

    logic [DW-1:0]   dig [MAXP];
    logic [MAXP-1:0] carry;
    logic [MAXP-1:0] tok;

    for (genvar i = 0; i < MAXP; i++) begin : g_cell
        localparam int NXT = (i == MAXP - 1) ? 0 : i + 1;
        logic cin;

        // the rightmost cell has no carry source
        assign cin = (i == MAXP - 1) ? 1'b0 : carry[NXT];

        cke_cell #(
            .DW  (DW),
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .radix_m1  (radix_m1),
            .leftmost  (leftmost),
            .len_m1    (len_m1),
            .digit_in  (dig[NXT]),
            .carry_in  (cin),
            .digit     (dig[i]),
            .carry_out (carry[i]),
            .tok       (tok[i])
        );
    end

    assign head         = dig[0];
    assign stat.any_tok = |tok;
    assign stat.wrap    = carry[0];

endmodule

[src/charset_keyspace_enumerator_utf8_unit.sv]
// ----------------------------------------------------------------------------
// charset keyspace enumerator, utf-8 output
// lists every string over a loaded charset, shortest first, one byte a beat
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis side with the opcode in tuser: write a charset
// entry, emit the next candidate, or restart. A next request streams the
// current candidate out as utf-8 bytes, leftmost character first, tlast on
// the final byte, then steps the odometer; once the keyspace is used up each
// next request returns one beat with tuser set, data zero and tlast high.
// A next request makes one full turn of the digit ring, with one ram lookup
// for each character and one beat per utf-8 byte up to 64 bytes, then a
// carry walk; m_axis stalls hold it up, and no new request is taken until it
// is done. The turn of the digit ring through cell 0 and the single read port
// of the charset ram set that order. Writing either config register restarts
// the enumeration; config is taken only while no request is in progress.
// ----------------------------------------------------------------------------
module charset_keyspace_enumerator_utf8_unit #(
    parameter int CHARSET_DEPTH = cke_pkg::CHARSET_DEPTH_DEF,
    parameter int MAX_POSITIONS = cke_pkg::MAX_POSITIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // request channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // entry_index[7:0], code_point[28:8]
    input  logic [1:0]                     s_axis_tuser,  // op[1:0]

    // result channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // out_byte[7:0]
    output logic                           m_axis_tlast,
    output logic [0:0]                     m_axis_tuser,  // exhausted[0]

    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cke_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cke_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "charset_keyspace_enumerator_utf8_unit_assert.svh"

    // digit width, position index width, ring turn counter width
    localparam int DW  = $clog2(CHARSET_DEPTH);
    localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int RCW = $clog2(MAX_POSITIONS + 1);
    // compare widths for clamping config values and range-checking the entry index
    localparam int CW  = ((DW + 1) > 9) ? (DW + 1) : 9;
    localparam int LW  = (RCW > 5) ? RCW : 5;
    localparam int IW  = ((DW + 1) > cke_pkg::IDX_W) ? (DW + 1) : cke_pkg::IDX_W;
    localparam int RST_LEN = (cke_pkg::MAX_LENGTH_RST > MAX_POSITIONS) ?
                             MAX_POSITIONS : cke_pkg::MAX_LENGTH_RST;
    localparam logic [RCW-1:0] ROT_FULL = RCW'(MAX_POSITIONS);

    // request fields
    cke_pkg::op_t                 in_op;
    logic [cke_pkg::IDX_W-1:0]    in_index;
    logic [cke_pkg::CP_W-1:0]     in_cp;
    logic                         in_acc;
    logic                         idx_in_range;

    // control state
    cke_pkg::state_t              state_reg, state_next;
    logic [RCW-1:0]               rot_cnt_reg, rot_cnt_next;
    logic [PW-1:0]                leftmost_reg, leftmost_next;
    logic [PW-1:0]                len_m1_reg, len_m1_next;
    logic [DW-1:0]                radix_m1_reg, radix_m1_next;
    logic                         done_reg, done_next;
    logic [PW-1:0]                walk_pos_reg, walk_pos_next;
    logic [cke_pkg::BCW-1:0]      bcnt_reg, bcnt_next;
    logic                         cut_reg, cut_next;
    logic [1:0]                   bidx_reg, bidx_next;
    logic [2:0]                   nbytes_reg, nbytes_next;
    logic                         char_final_reg, char_final_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    logic [cke_pkg::CP_W-1:0]     cp_reg, cp_next;
    logic [cke_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_exh_reg, out_exh_next;

    // datapath
    cke_pkg::chain_cmd_t          chain_cmd;
    cke_pkg::chain_stat_t         chain_stat;
    logic [DW-1:0]                head_digit;
    logic                         ram_we;
    logic [cke_pkg::CP_W-1:0]     ram_rdata;
    logic [CW-1:0]                cs_ext;
    logic [DW-1:0]                cfg_radix_m1;
    logic [LW-1:0]                ml_ext;
    logic [PW-1:0]                cfg_len_m1;
    logic                         pos_active;
    logic                         out_free;
    logic                         byte_end;
    logic                         budget_end;
    logic                         restart;

    assign in_op    = cke_pkg::op_t'(s_axis_tuser);
    assign in_index = s_axis_tdata[7:0];
    assign in_cp    = s_axis_tdata[28:8];

    assign s_axis_tready = (state_reg == cke_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == cke_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // slots past the table depth are dropped
    assign idx_in_range = (IW'(in_index) < IW'(CHARSET_DEPTH));

    // radix: 0 acts as 1, above the table depth acts as the depth
    assign cs_ext = CW'(cfg_data);
    always_comb
    begin
        if (cs_ext == '0)
        begin
            cfg_radix_m1 = '0;
        end else if (cs_ext > CW'(CHARSET_DEPTH))
        begin
            cfg_radix_m1 = DW'(CHARSET_DEPTH - 1);
        end else
        begin
            cfg_radix_m1 = DW'(cs_ext - 1'b1);
        end
    end

    // length from the low five bits: 0 acts as 1, above the ring size acts as the ring size
    assign ml_ext = LW'(cfg_data[4:0]);
    always_comb
    begin
        if (ml_ext == '0)
        begin
            cfg_len_m1 = '0;
        end else if (ml_ext > LW'(MAX_POSITIONS))
        begin
            cfg_len_m1 = PW'(MAX_POSITIONS - 1);
        end else
        begin
            cfg_len_m1 = PW'(ml_ext - 1'b1);
        end
    end

    // the position at cell 0 is the ring turn count
    assign pos_active = (rot_cnt_reg >= RCW'(leftmost_reg)) &&
                        (rot_cnt_reg <= RCW'(len_m1_reg));
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign byte_end   = ({1'b0, bidx_reg} == (nbytes_reg - 3'd1));
    assign budget_end = (bcnt_reg == cke_pkg::BCW'(cke_pkg::MAX_RESULTS - 1));

    // charset table, looked up by the digit at the head of the ring
    cke_ram #(
        .WIDTH (cke_pkg::CP_W),
        .DEPTH (CHARSET_DEPTH)
    ) u_charset (
        .clk   (clk),
        .we    (ram_we),
        .waddr (DW'(in_index)),
        .wdata (in_cp),
        .raddr (head_digit),
        .rdata (ram_rdata)
    );

    // odometer: one cell per position
    cke_chain #(
        .DW   (DW),
        .PW   (PW),
        .MAXP (MAX_POSITIONS)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (chain_cmd),
        .radix_m1 (radix_m1_reg),
        .leftmost (leftmost_reg),
        .len_m1   (len_m1_reg),
        .head     (head_digit),
        .stat     (chain_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        rot_cnt_next    = rot_cnt_reg;
        leftmost_next   = leftmost_reg;
        len_m1_next     = len_m1_reg;
        radix_m1_next   = radix_m1_reg;
        done_next       = done_reg;
        walk_pos_next   = walk_pos_reg;
        bcnt_next       = bcnt_reg;
        cut_next        = cut_reg;
        bidx_next       = bidx_reg;
        nbytes_next     = nbytes_reg;
        char_final_next = char_final_reg;
        cp_next         = cp_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_exh_next    = out_exh_reg;
        chain_cmd       = '0;
        ram_we          = 1'b0;
        restart         = 1'b0;

        case (state_reg)
            cke_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        cke_pkg::REG_CHARSET_SIZE:
                        begin
                            radix_m1_next = cfg_radix_m1;
                            restart       = 1'b1;
                        end
                        cke_pkg::REG_MAX_LENGTH:
                        begin
                            len_m1_next = cfg_len_m1;
                            restart     = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (in_acc)
                begin
                    case (in_op)
                        cke_pkg::OP_WRITE:
                        begin
                            ram_we = idx_in_range;
                        end
                        cke_pkg::OP_NEXT:
                        begin
                            if (done_reg)
                            begin
                                state_next = cke_pkg::ST_EXH;
                            end else
                            begin
                                rot_cnt_next = '0;
                                bcnt_next    = '0;
                                cut_next     = 1'b0;
                                state_next   = cke_pkg::ST_SCAN;
                            end
                        end
                        cke_pkg::OP_RESTART:
                        begin
                            restart = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (restart)
                begin
                    chain_cmd.clear = 1'b1;
                    leftmost_next   = len_m1_next;
                    done_next       = 1'b0;
                end
            end

            // one ring step a cycle, held during each lookup and emit; a full turn leaves the ring as it was
            cke_pkg::ST_SCAN:
            begin
                if (rot_cnt_reg == ROT_FULL)
                begin
                    chain_cmd.inject = 1'b1;
                    walk_pos_next    = len_m1_reg;
                    state_next       = cke_pkg::ST_WALK;
                end else
                begin
                    chain_cmd.rotate = 1'b1;
                    rot_cnt_next     = RCW'(rot_cnt_reg + 1'b1);
                    if (pos_active && !cut_reg)
                    begin
                        // ram samples the head digit at this edge
                        char_final_next = (rot_cnt_reg == RCW'(len_m1_reg));
                        state_next      = cke_pkg::ST_LOOK;
                    end
                end
            end

            cke_pkg::ST_LOOK:
            begin
                cp_next     = ram_rdata;
                nbytes_next = cke_pkg::utf8_len(ram_rdata);
                bidx_next   = '0;
                state_next  = cke_pkg::ST_EMIT;
            end

            cke_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cke_pkg::utf8_byte(cp_reg, bidx_reg);
                    // a candidate cut at the byte budget ends on its last kept byte
                    out_last_next  = (byte_end && char_final_reg) || budget_end;
                    out_exh_next   = 1'b0;
                    bcnt_next      = cke_pkg::BCW'(bcnt_reg + 1'b1);
                    bidx_next      = 2'(bidx_reg + 1'b1);
                    if (budget_end)
                    begin
                        cut_next = 1'b1;
                    end
                    if (byte_end || budget_end)
                    begin
                        state_next = cke_pkg::ST_SCAN;
                    end
                end
            end

            // carry token walks left one cell a cycle
            cke_pkg::ST_WALK:
            begin
                if (!chain_stat.any_tok)
                begin
                    state_next = cke_pkg::ST_IDLE;
                end else if (walk_pos_reg < leftmost_reg)
                begin
                    // carry ran past the leftmost: the string grows
                    leftmost_next = walk_pos_reg;
                    state_next    = cke_pkg::ST_IDLE;
                end else if ((walk_pos_reg == '0) && chain_stat.wrap)
                begin
                    done_next  = 1'b1;
                    state_next = cke_pkg::ST_IDLE;
                end else if (walk_pos_reg != '0)
                begin
                    walk_pos_next = PW'(walk_pos_reg - 1'b1);
                end
            end

            cke_pkg::ST_EXH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_exh_next   = 1'b1;
                    state_next     = cke_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cke_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cke_pkg::ST_IDLE;
            rot_cnt_reg    <= '0;
            leftmost_reg   <= PW'(RST_LEN - 1);
            len_m1_reg     <= PW'(RST_LEN - 1);
            radix_m1_reg   <= DW'(cke_pkg::CHARSET_SIZE_RST - 1);
            done_reg       <= 1'b0;
            walk_pos_reg   <= '0;
            bcnt_reg       <= '0;
            cut_reg        <= 1'b0;
            bidx_reg       <= '0;
            nbytes_reg     <= 3'd1;
            char_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else
        begin
            state_reg      <= state_next;
            rot_cnt_reg    <= rot_cnt_next;
            leftmost_reg   <= leftmost_next;
            len_m1_reg     <= len_m1_next;
            radix_m1_reg   <= radix_m1_next;
            done_reg       <= done_next;
            walk_pos_reg   <= walk_pos_next;
            bcnt_reg       <= bcnt_next;
            cut_reg        <= cut_next;
            bidx_reg       <= bidx_next;
            nbytes_reg     <= nbytes_next;
            char_final_reg <= char_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg       <= cp_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_exh_reg  <= out_exh_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_exh_reg;

    // a carry token only lives during the walk
    `CKE_ASSERT_IMPL(a_tok_only_walk, state_reg != cke_pkg::ST_WALK, !chain_stat.any_tok, "carry token outside walk")

    // a full ring turn always hands a carry into the chain
    `CKE_ASSERT_NEXT(a_turn_injects, (state_reg == cke_pkg::ST_SCAN) && (rot_cnt_reg == ROT_FULL), (state_reg == cke_pkg::ST_WALK) && chain_stat.any_tok, "no carry after full turn")

    // the leftmost position stays inside the frame
    `CKE_ASSERT_IMPL(a_left_in_frame, 1'b1, leftmost_reg <= len_m1_reg, "leftmost beyond length")

    // keyspace runs out only at full length
    `CKE_ASSERT_IMPL(a_done_full, done_reg, leftmost_reg == '0, "exhausted below full length")

endmodule

[dv/cke_candidate_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyspace enumerator result checker
// watches the request, result and config channels, keeps its own odometer
// and charset copy, and compares every result beat against the prediction
// ----------------------------------------------------------------------------
module cke_candidate_checker
    import cke_pkg::*;
#(
    parameter int CHARSET_DEPTH = CHARSET_DEPTH_DEF,
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // entry_index[7:0], code_point[28:8]
    input  logic [1:0]            s_axis_tuser,   // op[1:0]

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [7:0]            m_axis_tdata,   // out_byte[7:0]
    input  logic                  m_axis_tlast,
    input  logic [0:0]            m_axis_tuser,   // exhausted[0]

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    pending,
    output int                    errors,
    output int                    candidates,
    output int                    exhausted_replies
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              exh;
    } beat_t;

    logic [CP_W-1:0] entry_cp  [CHARSET_DEPTH];
    logic [7:0]      odo_digit [MAX_POSITIONS];
    int              odo_left;
    logic            odo_done;
    logic [8:0]      size_reg;
    logic [4:0]      len_reg;
    beat_t           beat_q [$];
    int              err_cnt;
    int              cand_cnt;
    int              exh_cnt;

    function automatic int cur_radix();
        int r;
        r = int'(size_reg);
        if (r == 0) r = 1;
        if (r > CHARSET_DEPTH) r = CHARSET_DEPTH;
        return r;
    endfunction

    function automatic int cur_len();
        int l;
        l = int'(len_reg);
        if (l == 0) l = 1;
        if (l > MAX_POSITIONS) l = MAX_POSITIONS;
        return l;
    endfunction

    function automatic void restart_odometer();
        int i;
        for (i = 0; i < MAX_POSITIONS; i++) odo_digit[i] = '0;
        odo_left = cur_len() - 1;
        odo_done = 1'b0;
    endfunction

    function automatic void reset_predictor();
        int i;
        size_reg = 9'(CHARSET_SIZE_RST);
        len_reg  = 5'(MAX_LENGTH_RST);
        for (i = 0; i < CHARSET_DEPTH; i++) entry_cp[i] = '0;
        restart_odometer();
        beat_q.delete();
        err_cnt  = 0;
        cand_cnt = 0;
        exh_cnt  = 0;
    endfunction

    // utf-8 form of a 21-bit value, surrogates and values past 10ffff included
    function automatic int utf8_pack(input logic [CP_W-1:0] cp, output logic [3:0][7:0] b);
        b = '0;
        if (cp < 21'h80)
        begin
            b[0] = {1'b0, cp[6:0]};
            return 1;
        end
        if (cp < 21'h800)
        begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000)
        begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            return 3;
        end
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic void step_odometer(input int len, input int radix);
        int i;
        int v;
        i = len;
        while (i > 0)
        begin
            i--;
            if (i < odo_left)
            begin
                // carry ran past the leftmost position, string grows
                odo_left     = i;
                odo_digit[i] = '0;
                break;
            end
            v = int'(odo_digit[i]) + 1;
            if (v >= radix)
            begin
                odo_digit[i] = 8'(v % radix);
                if (i == 0) odo_done = 1'b1;
            end
            else
            begin
                odo_digit[i] = 8'(v);
                break;
            end
        end
    endfunction

    function automatic void emit_candidate();
        int              len;
        int              radix;
        int              p;
        int              j;
        int              k;
        int              n;
        int              d;
        logic [CP_W-1:0] cp;
        logic [3:0][7:0] enc;
        beat_t           bt;
        if (odo_done)
        begin
            bt.data = '0;
            bt.last = 1'b1;
            bt.exh  = 1'b1;
            beat_q.push_back(bt);
            exh_cnt++;
            return;
        end
        len   = cur_len();
        radix = cur_radix();
        if (odo_left >= len) odo_left = len - 1;
        n = 0;
        for (p = odo_left; p < len && n < MAX_RESULTS; p++)
        begin
            d  = int'(odo_digit[p]);
            cp = (d < CHARSET_DEPTH) ? entry_cp[d] : '0;
            k  = utf8_pack(cp, enc);
            for (j = 0; j < k && n < MAX_RESULTS; j++)
            begin
                bt.data = enc[j];
                bt.last = 1'b0;
                bt.exh  = 1'b0;
                beat_q.push_back(bt);
                n++;
            end
        end
        if (n > 0)
        begin
            bt      = beat_q.pop_back();
            bt.last = 1'b1;
            beat_q.push_back(bt);
        end
        step_odometer(len, radix);
        cand_cnt++;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_CHARSET_SIZE)
        begin
            size_reg = val[8:0];
            restart_odometer();
        end
        else if (idx == REG_MAX_LENGTH)
        begin
            len_reg = val[4:0];
            restart_odometer();
        end
    endfunction

    function automatic void apply_request(input logic [1:0] op_bits,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [CP_W-1:0] cp);
        case (op_bits)
            OP_WRITE:
            begin
                if (int'(idx) < CHARSET_DEPTH) entry_cp[idx] = cp;
            end
            OP_NEXT:    emit_candidate();
            OP_RESTART: restart_odometer();
            default:    ;
        endcase
    endfunction

    function automatic void check_beat(input logic [7:0] data, input logic last,
                                       input logic exh);
        beat_t want;
        if (beat_q.size() == 0)
        begin
            if (err_cnt < 10)
                $display("%0t: unexpected result beat byte %02h last %0b exhausted %0b",
                         $time, data, last, exh);
            err_cnt++;
            return;
        end
        want = beat_q.pop_front();
        if (want.data !== data || want.last !== last || want.exh !== exh)
        begin
            if (err_cnt < 10)
                $display("%0t: beat mismatch, expected byte %02h last %0b exhausted %0b, got byte %02h last %0b exhausted %0b",
                         $time, want.data, want.last, want.exh, data, last, exh);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_predictor();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                apply_request(s_axis_tuser, s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W +: CP_W]);
            if (m_axis_tvalid && m_axis_tready)
                check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
        pending           <= beat_q.size();
        errors            <= err_cnt;
        candidates        <= cand_cnt;
        exhausted_replies <= exh_cnt;
    end

endmodule

[dv/tb_charset_keyspace_enumerator_utf8_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyspace enumerator testbench
// drives charset loads, next and restart requests under several radix and
// length settings with random pacing; the checker predicts every utf-8 beat
// ----------------------------------------------------------------------------
module tb_charset_keyspace_enumerator_utf8_unit;
    import cke_pkg::*;

    // pause after the last result before a config write or the verdict,
    // about one full next request at the default sizes
    localparam int DRAIN_HOLD     = 100;
    // cycles without any accepted request, beat or config write
    localparam int WATCHDOG_LIMIT = 5000;

    // codes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0]           OP_UNUSED  = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;  // entry_index[7:0], code_point[28:8]
    logic [1:0]            s_axis_tuser  = '0;  // op[1:0]

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // out_byte[7:0]
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;        // exhausted[0]

    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // checker status
    int                    exp_pending;
    int                    mismatch_count;
    int                    candidate_count;
    int                    exhausted_count;

    // pacing and bookkeeping of the stimulus side
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    req_count      = 0;
    int                    cfg_count      = 0;
    int                    setting_count  = 0;
    int                    tb_radix       = 1;
    int                    quiet_cycles   = 0;
    logic                  entry_written [256];

    charset_keyspace_enumerator_utf8_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cke_candidate_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .m_axis_tuser      (m_axis_tuser),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pending           (exp_pending),
        .errors            (mismatch_count),
        .candidates        (candidate_count),
        .exhausted_replies (exhausted_count)
    );

    always #5 clk = ~clk;

    // result side: random back-pressure at the current stall rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on handshake progress of all three channels
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d beats still due",
                     WATCHDOG_LIMIT, exp_pending);
            $display("tb_charset_keyspace_enumerator_utf8_unit failed");
            $finish;
        end
    end

    task automatic set_pace(input pace_t mode);
        case (mode)
            PACE_FREE:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            PACE_SENDER_GAPS:
            begin
                send_gap_pct   = 57;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER_STALLS:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 57;
            end
            default:
            begin
                send_gap_pct   = 11;
                recv_stall_pct = 11;
            end
        endcase
    endtask

    // spread code points over every utf-8 length, surrogates and
    // values past the unicode range
    function automatic logic [CP_W-1:0] rand_code_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 5))
            0:       cp = 21'($urandom_range(0, 'h7F));
            1:       cp = 21'($urandom_range('h80, 'h7FF));
            2:       cp = 21'($urandom_range('h800, 'hFFFF));
            3:       cp = 21'($urandom_range('h10000, 'h10FFFF));
            4:       cp = 21'($urandom_range('hD800, 'hDFFF));
            default: cp = 21'($urandom_range('h110000, 'h1FFFFF));
        endcase
        return cp;
    endfunction

    // one request; valid stays high on return unless a gap follows
    task automatic send_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [CP_W-1:0] cp);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, cp, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        req_count++;
        if (op == OP_WRITE) entry_written[idx] = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_count++;
    endtask

    // hold requests back until every predicted beat is out, then let the
    // block settle after any trailing write or restart
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (exp_pending != 0) @(posedge clk);
        repeat (DRAIN_HOLD) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] size, input logic [CFG_DATA_W-1:0] len);
        int r;
        drain_results();
        write_reg(REG_CHARSET_SIZE, size);
        write_reg(REG_MAX_LENGTH, len);
        r = int'(size);
        if (r == 0) r = 1;
        if (r > 256) r = 256;
        tb_radix = r;
        setting_count++;
    endtask

    // every entry the odometer can reach must hold a value before a next request
    task automatic fill_entries();
        int i;
        for (i = 0; i < tb_radix; i++)
            if (!entry_written[i]) send_req(OP_WRITE, 8'(i), rand_code_point());
    endtask

    // mostly next requests over a loaded charset, with reloads, restarts,
    // ignored opcodes and the odd full drain mixed in
    task automatic random_phase(input int count);
        int k;
        int pick;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_req(OP_NEXT, 8'($urandom), 21'($urandom));
            else if (pick < 80)
                send_req(OP_WRITE, 8'($urandom), rand_code_point());
            else if (pick < 87)
                send_req(OP_WRITE, 8'($urandom_range(0, tb_radix - 1)), rand_code_point());
            else if (pick < 93)
                send_req(OP_RESTART, 8'($urandom), 21'($urandom));
            else if (pick < 96)
                send_req(OP_UNUSED, 8'($urandom), 21'($urandom));
            else
                drain_results();
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < 256; k++) entry_written[k] = 1'b0;
        set_pace(PACE_FREE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, radix one, the string grows each time
        send_req(OP_WRITE, 8'd0, 21'h000041);
        send_req(OP_NEXT, 8'd0, 21'd0);
        send_req(OP_NEXT, 8'd0, 21'd0);

        // directed: every encoding boundary, surrogate and out-of-range value
        configure(9'd10, 9'd2);
        send_req(OP_WRITE, 8'd0, 21'h000000);
        send_req(OP_WRITE, 8'd1, 21'h00007F);
        send_req(OP_WRITE, 8'd2, 21'h000080);
        send_req(OP_WRITE, 8'd3, 21'h0007FF);
        send_req(OP_WRITE, 8'd4, 21'h000800);
        send_req(OP_WRITE, 8'd5, 21'h00D800);
        send_req(OP_WRITE, 8'd6, 21'h00FFFF);
        send_req(OP_WRITE, 8'd7, 21'h010000);
        send_req(OP_WRITE, 8'd8, 21'h10FFFF);
        send_req(OP_WRITE, 8'd9, 21'h1FFFFF);
        send_req(OP_WRITE, 8'd255, 21'h000000);
        for (k = 0; k < 4; k++) send_req(OP_NEXT, 8'hFF, 21'h1FFFFF);
        send_req(OP_RESTART, 8'd0, 21'd0);
        send_req(OP_NEXT, 8'd0, 21'd0);
        send_req(OP_UNUSED, 8'hFF, 21'h1FFFFF);
        send_req(OP_NEXT, 8'd0, 21'd0);

        // an unused register index changes nothing, not even the odometer
        drain_results();
        write_reg(REG_UNUSED, 9'h1FF);
        send_req(OP_NEXT, 8'd0, 21'd0);

        // directed: smallest keyspace, one candidate then exhausted replies
        configure(9'd1, 9'd1);
        send_req(OP_NEXT, 8'd0, 21'd0);
        send_req(OP_NEXT, 8'd0, 21'd0);
        send_req(OP_NEXT, 8'd0, 21'd0);
        send_req(OP_RESTART, 8'd0, 21'd0);
        send_req(OP_NEXT, 8'd0, 21'd0);

        // random: short keyspace, no idling, with a forced full drain mid-stream
        configure(9'd3, 9'd3);
        set_pace(PACE_FREE);
        fill_entries();
        random_phase(20);
        drain_results();
        random_phase(25);

        // binary keyspace, exhausted often
        configure(9'd2, 9'd2);
        set_pace(PACE_SENDER_GAPS);
        fill_entries();
        random_phase(35);

        // widest radix, whole charset loaded
        configure(9'd256, 9'd2);
        set_pace(PACE_RECEIVER_STALLS);
        fill_entries();
        random_phase(35);

        // radix zero acts as one, longest strings of four-byte characters
        configure(9'd0, 9'd16);
        set_pace(PACE_BOTH);
        send_req(OP_WRITE, 8'd0, 21'h10FFFF);
        for (k = 0; k < 18; k++) send_req(OP_NEXT, 8'($urandom), 21'($urandom));
        random_phase(10);

        // both registers past their range, upper length bits dropped
        configure(9'h1FF, 9'h1FF);
        set_pace(PACE_SENDER_GAPS);
        fill_entries();
        random_phase(30);

        // length zero acts as one
        configure(9'd5, 9'd0);
        set_pace(PACE_BOTH);
        fill_entries();
        random_phase(25);

        // length from the low five bits only
        configure(9'd4, 9'h0E3);
        set_pace(PACE_RECEIVER_STALLS);
        fill_entries();
        random_phase(30);

        // three random small settings, one under each pacing with gaps or stalls
        for (k = 0; k < 3; k++)
        begin
            configure(9'($urandom_range(1, 8)), 9'($urandom_range(1, 4)));
            set_pace(pace_t'(k + 1));
            fill_entries();
            random_phase(20);
        end

        drain_results();
        $display("covered %0d requests and %0d config writes over %0d settings",
                 req_count, cfg_count, setting_count);
        $display("checked %0d candidates and %0d exhausted replies, %0d mismatches",
                 candidate_count, exhausted_count, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_charset_keyspace_enumerator_utf8_unit passed");
        else
            $display("tb_charset_keyspace_enumerator_utf8_unit failed");
        $finish;
    end

endmodule
